// File: rtl/core/brd_pkg.sv
`default_nettype none
package brd_pkg;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] PAD_BYTE = 8'hff;
  localparam int unsigned HDR_LAST = 6;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_ACCEPT = 3'd1,
    KIND_DUP    = 3'd2,
    KIND_NAK    = 3'd3,
    KIND_LONG   = 3'd4
  } kind_t;

  typedef enum logic {
    REG_MAX_LENGTH = 1'b0,
    REG_CRC_POLY   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  peer_errors;
    logic [15:0] length;
    logic        verdict_last;
  } res_t;

  // Bits enter LSB first at bit 0; poly folds in on MSB carry.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [15:0] poly);
    logic [15:0] crc;
    logic        carry;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      carry = crc[15];
      crc = {crc[14:0], data[i]};
      if (carry) begin
        crc = crc ^ poly;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/brd_if.sv
`default_nettype none
interface brd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink   (input valid, input rx_byte, input timed_out, output ready);
endinterface

interface brd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  peer_errors;
  logic [15:0] length;
  logic        verdict_last;

  modport source (output valid, output kind, output data_byte, output peer_errors,
                  output length, output verdict_last, input ready);
  modport sink   (input valid, input kind, input data_byte, input peer_errors,
                  input length, input verdict_last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/block_receiver_deframer.sv
`default_nettype none
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    rx_byte[7:0], timed_out
// out_ch    out  valid/ready    kind[2:0], data_byte, peer_errors, length[15:0], verdict_last
// cfg_*     in   APB, no wait   max_length @0x0, crc_polynomial @0x4
//
// One transaction per cycle while in_ch.ready is high; each result is registered into the
// output buffer, except the verdict after a good ETX, which first passes the verdict stage.
// After a good ETX the second 0xff pad pass, the CRC compare and the block-number check run
// in a verdict stage: in_ch.ready drops for that one cycle, so a block costs one bubble.
// Reset is synchronous; no clearing pass, the block is ready right after reset.
// A two-entry output buffer (register plus skid) keeps inputs flowing while the
// sink stalls; in_ch.ready also drops while the skid entry is occupied.
module block_receiver_deframer
  import brd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  brd_in_if.sink           in_ch,
  brd_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 32'd1);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_ETX    = 2'd3
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             hidx_r, hidx_nxt;
  logic [15:0]            rx_crc_r, rx_crc_nxt;
  logic [15:0]            blen_r, blen_nxt;
  logic [15:0]            rblk_r, rblk_nxt;
  logic [7:0]             err_r, err_nxt;
  logic [LENGTH_BITS-1:0] dcnt_r, dcnt_nxt;
  logic [15:0]            rcrc_r, rcrc_nxt;
  logic [15:0]            exp_blk_r, exp_blk_nxt;
  logic                   pend_r, pend_nxt;
  logic [15:0]            pad_crc_r, pad_crc_nxt;
  logic [15:0]            max_len_r;
  logic [15:0]            poly_r;

  res_t                   main_r, skid_r, push_d;
  logic                   main_valid_r, skid_valid_r, push_v;

  logic                   accept, pop, cfg_wr;
  logic [LENGTH_BITS-1:0] dcnt_inc;
  logic [15:0]            final_crc;
  reg_idx_t               cfg_idx;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_MAX_LENGTH: cfg_prdata = {16'h0, max_len_r};
      REG_CRC_POLY:   cfg_prdata = {16'h0, poly_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready = !pend_r && !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = main_valid_r && out_ch.ready;

  assign dcnt_inc  = dcnt_r + 1'b1;
  assign final_crc = crc_byte(pad_crc_r, PAD_BYTE, poly_r);

  always_comb begin
    phase_nxt   = phase_r;
    hidx_nxt    = hidx_r;
    rx_crc_nxt  = rx_crc_r;
    blen_nxt    = blen_r;
    rblk_nxt    = rblk_r;
    err_nxt     = err_r;
    dcnt_nxt    = dcnt_r;
    rcrc_nxt    = rcrc_r;
    exp_blk_nxt = exp_blk_r;
    pend_nxt    = 1'b0;
    pad_crc_nxt = pad_crc_r;
    push_v      = 1'b0;
    push_d      = '0;

    if (accept) begin
      case (phase_r)
        PH_IDLE: begin
          if (!in_ch.timed_out && in_ch.rx_byte == STX_BYTE) begin
            phase_nxt = PH_HEADER;
            hidx_nxt  = '0;
            rcrc_nxt  = '0;
            err_nxt   = '0;
            dcnt_nxt  = '0;
          end
        end
        PH_HEADER: begin
          if (in_ch.timed_out) begin
            push_v             = 1'b1;
            push_d.kind        = KIND_NAK;
            push_d.peer_errors = err_r;
            push_d.verdict_last = 1'b1;
            phase_nxt          = PH_IDLE;
          end else begin
            case (hidx_r)
              3'd0: rx_crc_nxt = {8'h00, in_ch.rx_byte};
              3'd1: rx_crc_nxt = {in_ch.rx_byte, rx_crc_r[7:0]};
              3'd2: blen_nxt = {8'h00, in_ch.rx_byte};
              3'd3: blen_nxt = {in_ch.rx_byte, blen_r[7:0]};
              3'd4: begin
                rblk_nxt = {8'h00, in_ch.rx_byte};
                rcrc_nxt = crc_byte(rcrc_r, in_ch.rx_byte, poly_r);
              end
              3'd5: begin
                rblk_nxt = {in_ch.rx_byte, rblk_r[7:0]};
                rcrc_nxt = crc_byte(rcrc_r, in_ch.rx_byte, poly_r);
              end
              default: begin
                err_nxt  = in_ch.rx_byte;
                rcrc_nxt = crc_byte(rcrc_r, in_ch.rx_byte, poly_r);
              end
            endcase
            if (hidx_r < 3'(HDR_LAST)) begin
              hidx_nxt = hidx_r + 3'd1;
            end else begin
              hidx_nxt = '0;
              if (blen_r > max_len_r || blen_r > LEN_MASK) begin
                push_v              = 1'b1;
                push_d.kind         = KIND_LONG;
                push_d.peer_errors  = in_ch.rx_byte;
                push_d.verdict_last = 1'b1;
                phase_nxt           = PH_IDLE;
              end else begin
                dcnt_nxt  = '0;
                phase_nxt = (blen_r == 16'h0) ? PH_ETX : PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          if (in_ch.timed_out) begin
            push_v              = 1'b1;
            push_d.kind         = KIND_NAK;
            push_d.peer_errors  = err_r;
            push_d.verdict_last = 1'b1;
            phase_nxt           = PH_IDLE;
          end else begin
            rcrc_nxt         = crc_byte(rcrc_r, in_ch.rx_byte, poly_r);
            dcnt_nxt         = dcnt_inc;
            push_v           = 1'b1;
            push_d.kind      = KIND_DATA;
            push_d.data_byte = in_ch.rx_byte;
            if (16'(dcnt_inc) >= blen_r) begin
              phase_nxt = PH_ETX;
            end
          end
        end
        PH_ETX: begin
          phase_nxt = PH_IDLE;
          if (in_ch.timed_out || in_ch.rx_byte != ETX_BYTE) begin
            push_v              = 1'b1;
            push_d.kind         = KIND_NAK;
            push_d.peer_errors  = err_r;
            push_d.verdict_last = 1'b1;
          end else begin
            // first pad here, second pad and compare in the verdict stage
            pend_nxt    = 1'b1;
            pad_crc_nxt = crc_byte(rcrc_r, PAD_BYTE, poly_r);
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (pend_r) begin
      push_v              = 1'b1;
      push_d.peer_errors  = err_r;
      push_d.verdict_last = 1'b1;
      if (final_crc != rx_crc_r) begin
        push_d.kind = KIND_NAK;
      end else if (rblk_r != exp_blk_r) begin
        push_d.kind = KIND_DUP;
      end else begin
        push_d.kind   = KIND_ACCEPT;
        push_d.length = blen_r;
        exp_blk_nxt   = exp_blk_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hidx_r       <= '0;
      rx_crc_r     <= '0;
      blen_r       <= '0;
      rblk_r       <= '0;
      err_r        <= '0;
      dcnt_r       <= '0;
      rcrc_r       <= '0;
      exp_blk_r    <= '0;
      pend_r       <= 1'b0;
      max_len_r    <= 16'hffff;
      poly_r       <= 16'h1021;
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hidx_r    <= hidx_nxt;
      rx_crc_r  <= rx_crc_nxt;
      blen_r    <= blen_nxt;
      rblk_r    <= rblk_nxt;
      err_r     <= err_nxt;
      dcnt_r    <= dcnt_nxt;
      rcrc_r    <= rcrc_nxt;
      exp_blk_r <= exp_blk_nxt;
      pend_r    <= pend_nxt;
      pad_crc_r <= pad_crc_nxt;

      if (cfg_wr) begin
        case (cfg_idx)
          REG_MAX_LENGTH: max_len_r <= cfg_pwdata[15:0];
          REG_CRC_POLY:   poly_r    <= cfg_pwdata[15:0];
          default:        ;
        endcase
      end

      // advance the output buffer: skid feeds the register first
      if (!main_valid_r || pop) begin
        main_valid_r <= skid_valid_r || push_v;
        main_r       <= skid_valid_r ? skid_r : push_d;
        skid_valid_r <= skid_valid_r && push_v;
        if (skid_valid_r && push_v) begin
          skid_r <= push_d;
        end
      end else if (push_v) begin
        skid_valid_r <= 1'b1;
        skid_r       <= push_d;
      end
    end
  end

  assign out_ch.valid        = main_valid_r;
  assign out_ch.kind         = main_r.kind;
  assign out_ch.data_byte    = main_r.data_byte;
  assign out_ch.peer_errors  = main_r.peer_errors;
  assign out_ch.length       = main_r.length;
  assign out_ch.verdict_last = main_r.verdict_last;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held while output register empty");

  a_verdict_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> !pend_r)
    else $error("verdict stage held longer than one cycle");

  a_verdict_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !skid_valid_r)
    else $error("verdict stage fired with a full output buffer");

  a_verdict_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> phase_r == PH_IDLE)
    else $error("verdict stage active outside idle hunt");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (push_v && phase_r == PH_IDLE) |-> pend_r)
    else $error("result produced by an idle-phase transaction");

endmodule
`default_nettype wire
